/* rtl/itda_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itda_pkg
// shared types, constants and power-of-ten tables for the integer to decimal
// ascii converter
// ----------------------------------------------------------------------------
package itda_pkg;

    localparam int POS_W  = 4;
    localparam int MAG_W  = 32;
    localparam int WIDE_W = 36;
    localparam int CHAR_W = 6;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SIGN,
        ST_DIGIT
    } back_state_t;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic [POS_W-1:0] start;
    } entry_t;

    function automatic logic [WIDE_W-1:0] pow10(input logic [POS_W-1:0] idx);
        logic [WIDE_W-1:0] p;
        case (idx)
            4'd0:    p = 36'd1;
            4'd1:    p = 36'd10;
            4'd2:    p = 36'd100;
            4'd3:    p = 36'd1000;
            4'd4:    p = 36'd10000;
            4'd5:    p = 36'd100000;
            4'd6:    p = 36'd1000000;
            4'd7:    p = 36'd10000000;
            4'd8:    p = 36'd100000000;
            4'd9:    p = 36'd1000000000;
            4'd10:   p = 36'd10000000000;
            default: p = 36'd0;
        endcase
        return p;
    endfunction

    function automatic logic [WIDE_W-1:0] multiple(input logic [POS_W-1:0] idx,
                                                   input logic [3:0] k);
        logic [WIDE_W-1:0] p;
        p = pow10(idx);
        return WIDE_W'(p * {32'd0, k});
    endfunction

endpackage
`default_nettype wire

/* rtl/itda_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itda_front
// takes the signed input apart into sign and magnitude, saturates the
// magnitude to the digit count and finds the leading digit position
// ----------------------------------------------------------------------------
module itda_front #(
    parameter int MAX_DIGITS = 10
) (
    input  wire logic [31:0]      value,
    output itda_pkg::entry_t      entry
);

    localparam int EFF = (MAX_DIGITS < 10) ? MAX_DIGITS : 10;

    logic                            neg;
    logic [itda_pkg::MAG_W-1:0]      mag;
    logic [itda_pkg::MAG_W-1:0]      mag_sat;
    logic [itda_pkg::WIDE_W-1:0]     limit;
    logic [itda_pkg::POS_W-1:0]      start;

    assign neg   = value[31];
    assign mag   = neg ? (~value + 32'd1) : value;
    assign limit = itda_pkg::pow10(itda_pkg::POS_W'(EFF));

    always_comb
    begin
        if ({4'd0, mag} >= limit)
        begin
            mag_sat = itda_pkg::MAG_W'(limit - 36'd1);
        end
        else
        begin
            mag_sat = mag;
        end
    end

    // leading digit position: count of powers not above the magnitude
    always_comb
    begin
        start = '0;
        for (int p = 1; p < 10; p++)
        begin
            if (p < EFF && {4'd0, mag_sat} >= itda_pkg::pow10(itda_pkg::POS_W'(p)))
            begin
                start = start + 4'd1;
            end
        end
    end

    assign entry.neg   = neg;
    assign entry.mag   = mag_sat;
    assign entry.start = start;

endmodule
`default_nettype wire

/* rtl/itda_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itda_queue
// two-entry queue between the classifier and the character sequencer
// ----------------------------------------------------------------------------
module itda_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire itda_pkg::entry_t  push_entry,
    output logic                   pop_valid,
    input  wire logic              pop_ready,
    output itda_pkg::entry_t       pop_entry
);

    itda_pkg::entry_t entry_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_entry  = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_ptr_even: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with count");

    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop && count_reg == 2'd0) |=> pop_valid)
        else $error("queue lost a transaction");

endmodule
`default_nettype wire

/* rtl/itda_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itda_back
// character sequencer: emits the sign, then one decimal digit per cycle
// unless stalled, from the leading position down, through an output register
// ----------------------------------------------------------------------------
module itda_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire itda_pkg::entry_t              in_entry,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [itda_pkg::CHAR_W-1:0]        character,
    output logic                               last
);

    itda_pkg::back_state_t              state_reg;
    itda_pkg::back_state_t              state_next;
    logic [itda_pkg::MAG_W-1:0]         mag_reg;
    logic [itda_pkg::MAG_W-1:0]         mag_next;
    logic [itda_pkg::POS_W-1:0]         pos_reg;
    logic [itda_pkg::POS_W-1:0]         pos_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic [itda_pkg::CHAR_W-1:0]        char_reg;
    logic [itda_pkg::CHAR_W-1:0]        char_next;
    logic                               last_reg;
    logic                               last_next;
    logic                               slot;
    logic                               emit;
    logic [9:1]                         ge;
    logic [3:0]                         digit;
    logic [itda_pkg::WIDE_W-1:0]        sub;

    assign slot = !out_valid_reg || out_ready;

    // digit select by comparing against all nine multiples
    always_comb
    begin
        for (int k = 1; k < 10; k++)
        begin
            ge[k] = {4'd0, mag_reg} >= itda_pkg::multiple(pos_reg, 4'(k));
        end
    end

    assign digit = 4'($countones(ge));
    assign sub   = itda_pkg::multiple(pos_reg, digit);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            itda_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = in_entry.neg ? itda_pkg::ST_SIGN : itda_pkg::ST_DIGIT;
                end
            end
            itda_pkg::ST_SIGN:
            begin
                if (slot)
                begin
                    state_next = itda_pkg::ST_DIGIT;
                end
            end
            itda_pkg::ST_DIGIT:
            begin
                if (slot && pos_reg == '0)
                begin
                    state_next = itda_pkg::ST_IDLE;
                end
            end
            default: state_next = itda_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        in_ready  = 1'b0;
        emit      = 1'b0;
        mag_next  = mag_reg;
        pos_next  = pos_reg;
        char_next = char_reg;
        last_next = last_reg;
        case (state_reg)
            itda_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    mag_next = in_entry.mag;
                    pos_next = in_entry.start;
                end
            end
            itda_pkg::ST_SIGN:
            begin
                if (slot)
                begin
                    emit      = 1'b1;
                    char_next = itda_pkg::ASCII_MINUS;
                    last_next = 1'b0;
                end
            end
            itda_pkg::ST_DIGIT:
            begin
                if (slot)
                begin
                    emit      = 1'b1;
                    char_next = itda_pkg::ASCII_ZERO | {2'b00, digit};
                    last_next = (pos_reg == '0);
                    mag_next  = mag_reg - sub[itda_pkg::MAG_W-1:0];
                    pos_next  = pos_reg - 4'd1;
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= itda_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        pos_reg  <= pos_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == itda_pkg::ST_DIGIT && slot && pos_reg == '0)
        |=> (state_reg == itda_pkg::ST_IDLE && last_reg && out_valid_reg))
        else $error("final digit not flagged");

    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == itda_pkg::ST_SIGN && slot)
        |=> (char_reg == itda_pkg::ASCII_MINUS && !last_reg))
        else $error("sign transaction malformed");

    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (char_reg == itda_pkg::ASCII_MINUS ||
                           (char_reg >= 6'd48 && char_reg <= 6'd57)))
        else $error("character outside digit range");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == itda_pkg::ST_DIGIT) |-> {4'd0, mag_reg} <
        itda_pkg::pow10(pos_reg + 4'd1))
        else $error("remainder too large for digit position");

endmodule
`default_nettype wire

/* rtl/int_to_decimal_ascii_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_unit
// converts a signed 32-bit integer into its decimal ascii text
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid/in_ready carries one signed value per transaction.
//   output channel out_valid/out_ready carries one character per transaction,
//   '-' first for a negative value, then the digits without leading zeros;
//   last marks the final character of each number.
//   a value enters a two-entry queue in the cycle it is accepted; the
//   sequencer takes it from the queue when idle and emits one character
//   per cycle unless out_ready stalls it. the longest text is
//   "-2147483648". the queue lets up to two further values be accepted
//   while a number is being emitted.
//   when out_ready is low a valid character stays in the output register
//   and the sequencer waits; the input side keeps accepting until the
//   queue is full. reset empties the queue and the output register and
//   returns the sequencer to idle; nothing else needs clearing.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii_unit #(
    parameter int MAX_DIGITS = 10
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] value,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [5:0]       character,
    output logic             last
);

    itda_pkg::entry_t front_entry;
    itda_pkg::entry_t queue_entry;
    logic             queue_valid;
    logic             queue_ready;

    itda_front #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_front (
        .value (value),
        .entry (front_entry)
    );

    itda_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_ready (in_ready),
        .push_entry (front_entry),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_entry  (queue_entry)
    );

    itda_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (queue_valid),
        .in_ready  (queue_ready),
        .in_entry  (queue_entry),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .character (character),
        .last      (last)
    );

endmodule
`default_nettype wire
